// File: src/sss_pkg.sv
package sss_pkg;

    localparam int BARS = 16;
    localparam int BAR_W = $clog2(BARS + 1);
    localparam int AIM_DEN = BARS - 1;

    // span times bar, divided by bars minus one through an exact reciprocal
    localparam int AIM_PROD_W = 16 + BAR_W;
    localparam int AIM_SHIFT = AIM_PROD_W + $clog2(AIM_DEN);
    localparam int AIM_RECIP_W = AIM_PROD_W + 1;
    localparam logic [AIM_RECIP_W-1:0] AIM_RECIP = AIM_RECIP_W'(
        ((64'd1 << AIM_SHIFT) + 64'(AIM_DEN) - 64'd1) / 64'(AIM_DEN));
    localparam int AIM_MUL_W = AIM_PROD_W + AIM_RECIP_W;

    // scan time divided by bars, same scheme
    localparam int BUD_SHIFT = 16 + $clog2(BARS);
    localparam int BUD_RECIP_W = 17;
    localparam logic [BUD_RECIP_W-1:0] BUD_RECIP = BUD_RECIP_W'(
        ((64'd1 << BUD_SHIFT) + 64'(BARS) - 64'd1) / 64'(BARS));
    localparam int BUD_MUL_W = 16 + BUD_RECIP_W;
    localparam logic [15:0] BUDGET_FLOOR_MS = 16'd80;

    localparam logic [9:0] SETTLE_RESET_MS = 10'd50;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_MOVE    = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_MEASURE = 3'd3,
        PH_WAIT    = 3'd4,
        PH_NEXT    = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CFG_AIM_LO    = 2'd0,
        CFG_AIM_HI    = 2'd1,
        CFG_SCAN_TIME = 2'd2,
        CFG_SETTLE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] aim_lo;
        logic [15:0] aim_hi;
        logic [15:0] sweep_ms;
        logic [9:0]  settle_ms;
    } t_cfg;

    typedef struct packed {
        logic        servo_command;
        logic        reading_new;
        logic [4:0]  bar_number;
        logic [15:0] measured_mm;
        logic        measured_valid;
        logic        running;
        logic        finished;
        t_phase      phase_now;
    } t_status;

    typedef struct packed {
        t_status                 st;
        logic [AIM_PROD_W-1:0]   aim_prod;
        logic [15:0]             aim_base;
    } t_s1;

    typedef struct packed {
        t_status     st;
        logic [15:0] servo_position;
    } t_result;

endpackage

// File: src/sss_cfg.sv
module sss_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    output sss_pkg::t_cfg       o_cfg
);

    sss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.aim_lo    <= '0;
            r_cfg.aim_hi    <= '0;
            r_cfg.sweep_ms  <= '0;
            r_cfg.settle_ms <= sss_pkg::SETTLE_RESET_MS;
        end else if (i_cfg_wr_en) begin
            unique case (sss_pkg::t_cfg_idx'(i_cfg_index))
                sss_pkg::CFG_AIM_LO:    r_cfg.aim_lo    <= i_cfg_wdata;
                sss_pkg::CFG_AIM_HI:    r_cfg.aim_hi    <= i_cfg_wdata;
                sss_pkg::CFG_SCAN_TIME: r_cfg.sweep_ms  <= i_cfg_wdata;
                sss_pkg::CFG_SETTLE:    r_cfg.settle_ms <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/sss_ctrl.sv
module sss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_load,
    input  sss_pkg::t_op        i_op,
    input  logic [31:0]         i_now_ms,
    input  logic [15:0]         i_distance_mm,
    input  logic                i_distance_ok,
    input  sss_pkg::t_cfg       i_cfg,
    output sss_pkg::t_s1        o_s1
);

    sss_pkg::t_phase              r_phase;
    logic [31:0]                  r_phase_start;
    logic [31:0]                  r_bar_start;
    logic [sss_pkg::BAR_W-1:0]    r_bar_counter;
    logic                         r_active;
    logic                         r_finished;
    logic [15:0]                  r_scan_snap;
    logic [15:0]                  r_budget;
    sss_pkg::t_s1                 r_s1;

    sss_pkg::t_phase              n_phase;
    logic [31:0]                  n_phase_start;
    logic [31:0]                  n_bar_start;
    logic [sss_pkg::BAR_W-1:0]    n_bar_counter;
    logic                         n_active;
    logic                         n_finished;
    logic [15:0]                  n_scan_snap;
    logic [15:0]                  n_budget;
    sss_pkg::t_s1                 n_s1;

    logic [sss_pkg::BUD_MUL_W-1:0] w_bud_prod;
    logic [15:0]                  w_bud_quot;
    logic [15:0]                  w_span;
    logic [31:0]                  w_phase_elapsed;
    logic [31:0]                  w_bar_elapsed;
    logic                         w_cmd;
    logic                         w_upd;
    logic [15:0]                  w_mm;
    logic                         w_mv;

    // per-bar budget follows the scan time captured at start
    assign w_bud_prod = sss_pkg::BUD_MUL_W'(r_scan_snap)
                      * sss_pkg::BUD_MUL_W'(sss_pkg::BUD_RECIP);
    assign w_bud_quot = 16'(w_bud_prod >> sss_pkg::BUD_SHIFT);
    assign n_budget   = (w_bud_quot < sss_pkg::BUDGET_FLOOR_MS) ?
                        sss_pkg::BUDGET_FLOOR_MS : w_bud_quot;

    // reversed limits collapse every bar onto the low limit
    assign w_span = (i_cfg.aim_hi >= i_cfg.aim_lo) ?
                    (i_cfg.aim_hi - i_cfg.aim_lo) : 16'd0;

    assign w_phase_elapsed = i_now_ms - r_phase_start;
    assign w_bar_elapsed   = i_now_ms - r_bar_start;

    always_comb begin
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        n_bar_start   = r_bar_start;
        n_bar_counter = r_bar_counter;
        n_active      = r_active;
        n_finished    = r_finished;
        n_scan_snap   = r_scan_snap;
        w_cmd         = 1'b0;
        w_upd         = 1'b0;
        w_mm          = 16'd0;
        w_mv          = 1'b0;

        unique case (i_op)
            sss_pkg::OP_INIT: begin
                n_bar_counter = '0;
                n_active      = 1'b0;
                n_finished    = 1'b0;
                n_phase       = sss_pkg::PH_IDLE;
            end
            sss_pkg::OP_START: begin
                n_bar_counter = '0;
                n_active      = 1'b1;
                n_finished    = 1'b0;
                n_scan_snap   = i_cfg.sweep_ms;
                n_phase       = sss_pkg::PH_MOVE;
                n_phase_start = i_now_ms;
            end
            sss_pkg::OP_STOP: begin
                n_active = 1'b0;
                n_phase  = sss_pkg::PH_IDLE;
            end
            sss_pkg::OP_STEP: begin
                if (r_active) begin
                    unique case (r_phase)
                        sss_pkg::PH_MOVE: begin
                            n_bar_start   = i_now_ms;
                            n_phase_start = i_now_ms;
                            w_cmd         = 1'b1;
                            n_phase       = sss_pkg::PH_SETTLE;
                        end
                        sss_pkg::PH_SETTLE: begin
                            if (w_phase_elapsed >= 32'(i_cfg.settle_ms)) begin
                                n_phase = sss_pkg::PH_MEASURE;
                            end
                        end
                        sss_pkg::PH_MEASURE: begin
                            w_upd         = 1'b1;
                            w_mm          = i_distance_mm;
                            w_mv          = i_distance_ok;
                            n_phase_start = i_now_ms;
                            n_phase       = sss_pkg::PH_WAIT;
                        end
                        sss_pkg::PH_WAIT: begin
                            if (w_bar_elapsed >= 32'(r_budget)) begin
                                n_phase = sss_pkg::PH_NEXT;
                            end
                        end
                        sss_pkg::PH_NEXT: begin
                            n_bar_counter = r_bar_counter + 1'b1;
                            if (n_bar_counter >= sss_pkg::BAR_W'(sss_pkg::BARS)) begin
                                n_finished = 1'b1;
                                n_active   = 1'b0;
                                n_phase    = sss_pkg::PH_DONE;
                            end else begin
                                n_phase = sss_pkg::PH_MOVE;
                            end
                        end
                        sss_pkg::PH_DONE: begin
                            n_phase = sss_pkg::PH_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        n_s1.st.servo_command  = w_cmd;
        n_s1.st.reading_new    = w_upd;
        n_s1.st.bar_number     = 5'(n_bar_counter);
        n_s1.st.measured_mm    = w_mm;
        n_s1.st.measured_valid = w_mv;
        n_s1.st.running        = n_active;
        n_s1.st.finished       = n_finished;
        n_s1.st.phase_now      = n_phase;
        // bar counter is below BARS whenever a move is issued
        n_s1.aim_prod = sss_pkg::AIM_PROD_W'(w_span)
                      * sss_pkg::AIM_PROD_W'(r_bar_counter);
        n_s1.aim_base = i_cfg.aim_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sss_pkg::PH_IDLE;
            r_phase_start <= '0;
            r_bar_start   <= '0;
            r_bar_counter <= '0;
            r_active      <= 1'b0;
            r_finished    <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_phase_start <= n_phase_start;
            r_bar_start   <= n_bar_start;
            r_bar_counter <= n_bar_counter;
            r_active      <= n_active;
            r_finished    <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_scan_snap <= n_scan_snap;
        end
        r_budget <= n_budget;
        if (i_load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// File: src/sss_aim.sv
module sss_aim (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load2,
    input  logic                i_load3,
    input  logic                i_s2_valid,
    input  sss_pkg::t_s1        i_s1,
    output sss_pkg::t_result    o_result
);

    logic [sss_pkg::AIM_MUL_W-1:0] w_prod;
    logic [15:0]                  w_target;

    sss_pkg::t_status             r_s2_st;
    logic [15:0]                  r_s2_quot;
    logic [15:0]                  r_s2_base;
    logic [15:0]                  r_held;
    sss_pkg::t_result             r_out;

    // exact floor division by bars minus one for every product value
    assign w_prod = sss_pkg::AIM_MUL_W'(i_s1.aim_prod)
                  * sss_pkg::AIM_MUL_W'(sss_pkg::AIM_RECIP);

    assign w_target = r_s2_base + r_s2_quot;

    always_ff @(posedge i_clk) begin
        if (i_load2) begin
            r_s2_st   <= i_s1.st;
            r_s2_quot <= 16'(w_prod >> sss_pkg::AIM_SHIFT);
            r_s2_base <= i_s1.aim_base;
        end
        if (i_load3) begin
            r_out.st             <= r_s2_st;
            r_out.servo_position <= r_s2_st.servo_command ? w_target : r_held;
        end
    end

    // held target only moves when a real move transfer leaves this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_load3 && i_s2_valid && r_s2_st.servo_command) begin
            r_held <= w_target;
        end
    end

    assign o_result = r_out;

endmodule

// File: src/servo_sonar_sweep_sequencer_core.sv
// an input transfer reaches the output through the sequencer, aim divide and output registers
// throughput: one item per cycle while the output is not held, a three-stage pipeline (sequencer, aim divide, output)
// stages advance independently, so a held output stalls only the stages behind it
// reset (synchronous, active low) returns the sequencer to idle, empties the pipeline,
// clears the held servo target and loads register defaults (settle 50 ms, others 0)
module servo_sonar_sweep_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // now_ms[31:0], distance_mm[47:32], distance_ok[48]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // servo_command[0], servo_position[16:1], reading_new[17], bar_number[22:18],
    // measured_mm[38:23], measured_valid[39], running[40], finished[41], phase_now[44:42]
    output logic [47:0] o_m_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    sss_pkg::t_cfg    w_cfg;
    sss_pkg::t_s1     w_s1;
    sss_pkg::t_result w_result;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_ready1;
    logic w_ready2;
    logic w_ready3;
    logic w_accept;

    assign w_ready3 = !r_v3 || i_m_tready;
    assign w_ready2 = !r_v2 || w_ready3;
    assign w_ready1 = !r_v1 || w_ready2;
    assign w_accept = i_s_tvalid && w_ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ready1) begin
                r_v1 <= i_s_tvalid;
            end
            if (w_ready2) begin
                r_v2 <= r_v1;
            end
            if (w_ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    sss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    sss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_load        (w_ready1),
        .i_op          (sss_pkg::t_op'(i_s_tuser)),
        .i_now_ms      (i_s_tdata[31:0]),
        .i_distance_mm (i_s_tdata[47:32]),
        .i_distance_ok (i_s_tdata[48]),
        .i_cfg         (w_cfg),
        .o_s1          (w_s1)
    );

    sss_aim u_aim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load2    (w_ready2),
        .i_load3    (w_ready3),
        .i_s2_valid (r_v2),
        .i_s1       (w_s1),
        .o_result   (w_result)
    );

    assign o_s_tready = w_ready1;
    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {
        3'b000,
        3'(w_result.st.phase_now),
        w_result.st.finished,
        w_result.st.running,
        w_result.st.measured_valid,
        w_result.st.measured_mm,
        w_result.st.bar_number,
        w_result.st.reading_new,
        w_result.servo_position,
        w_result.st.servo_command
    };

endmodule
